// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules; clocked on clk, disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lfu_pkg.sv
// Package: widths, constants and controller/datapath signal types of the LFU cache
package lfu_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int STAMP_W   = 48;
  localparam int COUNT_W   = 32;
  localparam int CAP_REG_W = 5;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CAP_REG_W-1:0] CAP_RESET   = 5'd16;
  localparam logic [VAL_W-1:0]     MISS_VALUE  = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0]     PUT_VALUE   = 32'h0000_0000;
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0]   COUNT_ONE   = 32'd1;
  localparam logic [STAMP_W-1:0]   STAMP_RESET = 48'd1;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_room;
  } lfu_status_t;

endpackage

// File: hw/rtl/lfu_in_if.sv
// Request channel interface: valid/ready handshake with operation, key and value
interface lfu_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] lookup_key;
  logic signed [31:0] store_value;

  modport source(output valid, mode, lookup_key, store_value, input ready);
  modport sink(input valid, mode, lookup_key, store_value, output ready);
endinterface

// File: hw/rtl/lfu_out_if.sv
// Response channel interface: valid/ready handshake with hit flag and read value
interface lfu_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;

  modport source(output valid, hit, read_value, input ready);
  modport sink(input valid, hit, read_value, output ready);
endinterface

// File: hw/rtl/lfu_cache_key_store.sv
// Top level of the LFU key-value cache: APB capacity register, controller and datapath
//
// Usage:
//   req  (valid/ready): one transaction per get (mode 0) or put (mode 1) with a
//        32-bit key and value. req.ready is high while no transaction is in work.
//   resp (valid/ready): exactly one transaction per request, in order: hit flag
//        and read_value (get hit: stored value, get miss: -1, put: 0).
//   APB: register capacity_in_use at byte address 0, 5 bits, reset 16; write
//        only while the block is idle.
// Operation: after accept, the single memory read port walks every entry once,
//   one per cycle, doing key match, free-slot and victim search together; the
//   read register is then drained, and the update is committed into the response
//   register, waiting in commit while a held response is not yet taken. The next
//   request is accepted only after the commit, once the block is back in idle.
// Reset: all entries invalid, access counter 1, no entries held, no response.
// Receiver stall: the response register holds its transaction; the block still
//   accepts and scans the next request, then waits in commit until resp is taken.
module lfu_cache_key_store #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  lfu_in_if.sink                       req,
  lfu_out_if.source                    resp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::DATA_W-1:0]   pwdata,
  output logic [lfu_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import lfu_pkg::*;

  logic [CAP_REG_W-1:0] capacity_in_use;
  lfu_cmd_t             cmd;
  lfu_status_t          status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity_in_use <= pwdata[CAP_REG_W-1:0];
    end
  end

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lfu_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .capacity_in_use (capacity_in_use),
    .mode            (req.mode),
    .lookup_key      (req.lookup_key),
    .store_value     (req.store_value),
    .resp            (resp)
  );

endmodule

// File: hw/rtl/lfu_ctrl.sv
// Controller FSM: accept, scan all entries, drain the read pipe, commit the update
`include "assert_macros.svh"

module lfu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  lfu_pkg::lfu_status_t status,
  output lfu_pkg::lfu_cmd_t    cmd
);
  import lfu_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready  = (state == ST_IDLE);
  assign cmd.load   = (state == ST_IDLE) && req_valid;
  assign cmd.issue  = (state == ST_SCAN);
  assign cmd.commit = (state == ST_COMMIT) && status.out_room;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req_valid) state_next = ST_SCAN;
      ST_SCAN:   if (status.scan_last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_COMMIT;
      ST_COMMIT: if (status.out_room) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_NEXT(a_drain_to_commit, state == ST_DRAIN, state == ST_COMMIT, "drain must lead to commit")
  `ASSERT_NEXT(a_accept_starts_scan, cmd.load, state == ST_SCAN, "accepted transaction must start a scan")

endmodule

// File: hw/rtl/lfu_datapath.sv
// Datapath: entry memories, valid bits, scan pipeline, match/victim search, update, output reg
`include "assert_macros.svh"

module lfu_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lfu_pkg::lfu_cmd_t               cmd,
  output lfu_pkg::lfu_status_t            status,
  input  logic [lfu_pkg::CAP_REG_W-1:0]   capacity_in_use,
  input  logic                            mode,
  input  logic signed [lfu_pkg::KEY_W-1:0] lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0] store_value,
  lfu_out_if.source                       resp
);
  import lfu_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HELD_W = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (HELD_W > CAP_REG_W) ? HELD_W : CAP_REG_W;
  localparam int RANK_W = COUNT_W + STAMP_W;

  logic [KEY_W-1:0]   key_mem   [CAPACITY];
  logic [VAL_W-1:0]   value_mem [CAPACITY];
  logic [STAMP_W-1:0] stamp_mem [CAPACITY];
  logic [COUNT_W-1:0] count_mem [CAPACITY];
  logic [CAPACITY-1:0] entry_valid;

  logic [STAMP_W-1:0] access_counter;
  logic [HELD_W-1:0]  entries_held;

  logic               op_mode;
  logic [KEY_W-1:0]   op_key;
  logic [VAL_W-1:0]   op_value;

  logic [IDX_W-1:0]   scan_idx;
  logic               rd_live;
  logic [IDX_W-1:0]   rd_idx;
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_value;
  logic [STAMP_W-1:0] rd_stamp;
  logic [COUNT_W-1:0] rd_count;

  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [VAL_W-1:0]   hit_value;
  logic [COUNT_W-1:0] hit_count;
  logic               have_free;
  logic [IDX_W-1:0]   free_idx;
  logic               have_best;
  logic [IDX_W-1:0]   best_idx;
  logic [RANK_W-1:0]  best_rank;

  logic               rd_entry_valid;
  logic [RANK_W-1:0]  rd_rank;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   limit;
  logic               limit_zero;
  logic               room;
  logic               do_touch;
  logic               do_insert;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [COUNT_W-1:0] count_sat;
  logic [COUNT_W-1:0] count_wr;

  assign status.scan_last = (scan_idx == IDX_W'(CAPACITY - 1));
  assign status.out_room  = !resp.valid || resp.ready;

  // read pipe: one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_key   <= key_mem[scan_idx];
      rd_value <= value_mem[scan_idx];
      rd_stamp <= stamp_mem[scan_idx];
      rd_count <= count_mem[scan_idx];
    end
    rd_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live  <= 1'b0;
      scan_idx <= '0;
    end else begin
      rd_live <= cmd.issue;
      if (cmd.load) begin
        scan_idx <= '0;
      end else if (cmd.issue && !status.scan_last) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode;
      op_key   <= lookup_key;
      op_value <= store_value;
    end
  end

  // search: key match, first free slot, lowest (count, stamp) victim
  assign rd_entry_valid = entry_valid[rd_idx];
  assign rd_rank        = {rd_count, rd_stamp};

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      found     <= 1'b0;
      have_free <= 1'b0;
      have_best <= 1'b0;
    end else if (rd_live) begin
      if (rd_entry_valid && rd_key == op_key && !found) begin
        found <= 1'b1;
      end
      if (!rd_entry_valid && !have_free) begin
        have_free <= 1'b1;
      end
      if (rd_entry_valid && (!have_best || rd_rank < best_rank)) begin
        have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_live) begin
      if (rd_entry_valid && rd_key == op_key && !found) begin
        hit_idx   <= rd_idx;
        hit_value <= rd_value;
        hit_count <= rd_count;
      end
      if (!rd_entry_valid && !have_free) begin
        free_idx <= rd_idx;
      end
      if (rd_entry_valid && (!have_best || rd_rank < best_rank)) begin
        best_idx  <= rd_idx;
        best_rank <= rd_rank;
      end
    end
  end

  // update decision
  assign cap_ext    = CMP_W'(capacity_in_use);
  assign limit      = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
  assign limit_zero = (limit == '0);
  assign room       = CMP_W'(entries_held) < limit;
  assign do_touch   = found && (op_mode == MODE_GET || !limit_zero);
  assign do_insert  = (op_mode == MODE_PUT) && !limit_zero && !found &&
                      (room ? have_free : have_best);
  assign wr_en      = cmd.commit && (do_touch || do_insert);
  assign wr_idx     = found ? hit_idx : (room ? free_idx : best_idx);
  assign count_sat  = (hit_count == COUNT_MAX) ? hit_count : hit_count + 1'b1;
  assign count_wr   = do_insert ? COUNT_ONE : count_sat;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_idx] <= access_counter;
      count_mem[wr_idx] <= count_wr;
      if (op_mode == MODE_PUT) begin
        value_mem[wr_idx] <= op_value;
      end
      if (do_insert) begin
        key_mem[wr_idx] <= op_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      entries_held   <= '0;
      access_counter <= STAMP_RESET;
    end else if (wr_en) begin
      access_counter <= access_counter + 1'b1;
      if (do_insert) begin
        entry_valid[wr_idx] <= 1'b1;
        if (room) begin
          entries_held <= entries_held + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp.valid <= 1'b0;
    end else if (cmd.commit) begin
      resp.valid <= 1'b1;
    end else if (resp.ready) begin
      resp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      resp.hit        <= found;
      resp.read_value <= (op_mode == MODE_PUT) ? PUT_VALUE :
                         (found ? hit_value : MISS_VALUE);
    end
  end

  `ASSERT_ALWAYS(a_held_matches_valid, $countones(entry_valid) == int'(entries_held), "entries_held out of step with valid bits")
  `ASSERT_NEXT(a_commit_fills_output, cmd.commit, resp.valid, "commit must present a response")

endmodule
